### rtl/core/afhtp_pkg.sv
package afhtp_pkg;

   localparam int NUM_PORTS   = 2;
   localparam int PORT_W      = 1;
   localparam int TIME_W      = 32;
   localparam int RATE_W      = 4;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 4;

   localparam logic [TIME_W-1:0] HOLD_TOGGLE_US = TIME_W'(3000000);

   // half period = US_PER_SECOND / (2 * rate)
   localparam int QUOT_W  = 20;
   localparam int DIVS_W  = RATE_W + 1;
   localparam int DCNT_W  = 5;
   localparam logic [QUOT_W-1:0] US_PER_SECOND = QUOT_W'(1000000);

   localparam logic [CSR_IDX_W-1:0] REG_MODE_PORT0 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MODE_PORT1 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_RATE_PORT0 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_RATE_PORT1 = CSR_IDX_W'(3);

   typedef struct packed {
      logic [NUM_PORTS-1:0]             mode;
      logic [NUM_PORTS-1:0][RATE_W-1:0] rate;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [DIVS_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_sts_type;

endpackage

### rtl/core/afhtp_req_if.sv
interface afhtp_req_if import afhtp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PORT_W-1:0] port;
   logic              fire_level;
   logic [TIME_W-1:0] now_us;

   modport source (output valid, port, fire_level, now_us, input ready);
   modport sink   (input valid, port, fire_level, now_us, output ready);
endinterface

### rtl/core/afhtp_rsp_if.sv
interface afhtp_rsp_if ();
   logic valid;
   logic ready;
   logic effective_fire;
   logic autofire_on;

   modport source (output valid, effective_fire, autofire_on, input ready);
   modport sink   (input valid, effective_fire, autofire_on, output ready);
endinterface

### rtl/core/afhtp_csr_if.sv
interface afhtp_csr_if import afhtp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/afhtp_csr.sv
module afhtp_csr import afhtp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   afhtp_csr_if.sink   csr,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_MODE_PORT0: cfg_in.mode[0] = csr.data[0];
            REG_MODE_PORT1: cfg_in.mode[1] = csr.data[0];
            REG_RATE_PORT0: cfg_in.rate[0] = csr.data[RATE_W-1:0];
            REG_RATE_PORT1: cfg_in.rate[1] = csr.data[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= '0;
         for (int i = 0; i < NUM_PORTS; i++) begin
            cfg_ff.rate[i] <= RATE_W'(1);
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/afhtp_div.sv
module afhtp_div import afhtp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] divs_ff, divs_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [DIVS_W:0]   trial;
   logic [DIVS_W:0]   diff;

   assign trial = {rem_ff, US_PER_SECOND[cnt_ff]};
   assign diff  = trial - {1'b0, divs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      divs_in = divs_ff;
      quot_in = quot_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(QUOT_W - 1);
         rem_in  = '0;
         divs_in = cmd.divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (!diff[DIVS_W]) begin
            rem_in = diff[DIVS_W-1:0];
         end else begin
            rem_in = trial[DIVS_W-1:0];
         end
         quot_in = {quot_ff[QUOT_W-2:0], ~diff[DIVS_W]};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - DCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      divs_ff <= divs_in;
      quot_ff <= quot_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quot_ff;

endmodule

### rtl/core/autofire_hold_toggle_pulse_core.sv
// channel | dir | handshake    | payload
// req     | in  | valid/ready  | port, fire_level, now_us
// rsp     | out | valid/ready  | effective_fire, autofire_on
// csr     | in  | valid/ready  | index, data (always ready)
//
// A standby-mode item passes the hold, divide, phase and done steps before rsp valid;
// the 20-step restoring divider that forms the half period takes up most of that. A
// mode-off item skips the divider. req is ready only in idle, from the cycle in
// which rsp valid rises, so an item is taken only after the last one is finished.
// A finished item waits in the rsp register while the next item is taken, and the
// sequencer stalls in its last step when the rsp register is still full.
// Synchronous reset clears all per-port flags, timestamps, mode bits and rsp valid, and sets each rate to 1.
module autofire_hold_toggle_pulse_core import afhtp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   afhtp_req_if.sink req,
   afhtp_rsp_if.source rsp,
   afhtp_csr_if.sink csr
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_HOLD  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_PHASE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   cfg_type     cfg;
   div_cmd_type div_cmd;
   div_sts_type div_sts;

   logic [2:0]              state_ff, state_in;
   logic [PORT_W-1:0]       port_ff, port_in;
   logic                    raw_ff, raw_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic                    fire_ff, fire_in;
   logic                    on_ff, on_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_fire_ff, rsp_fire_in;
   logic                    rsp_on_ff, rsp_on_in;

   logic [NUM_PORTS-1:0]             active_ff, active_in;
   logic [NUM_PORTS-1:0]             track_ff, track_in;
   logic [NUM_PORTS-1:0]             wait_ff, wait_in;
   logic [NUM_PORTS-1:0]             phase_ff, phase_in;
   logic [NUM_PORTS-1:0][TIME_W-1:0] hold_start_ff, hold_start_in;
   logic [NUM_PORTS-1:0][TIME_W-1:0] phase_start_ff, phase_start_in;

   logic              port_ok;
   logic [RATE_W-1:0] rate_eff;
   logic [TIME_W-1:0] hold_elapsed;
   logic [TIME_W-1:0] phase_elapsed;
   logic              pulse;

   afhtp_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   afhtp_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   assign port_ok       = ({1'b0, port_ff} < (PORT_W + 1)'(NUM_PORTS));
   assign rate_eff      = (cfg.rate[port_ff] == '0) ? RATE_W'(1) : cfg.rate[port_ff];
   assign hold_elapsed  = now_ff - hold_start_ff[port_ff];
   assign phase_elapsed = now_ff - phase_start_ff[port_ff];

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.effective_fire = rsp_fire_ff;
   assign rsp.autofire_on   = rsp_on_ff;

   always_comb begin
      state_in       = state_ff;
      port_in        = port_ff;
      raw_in         = raw_ff;
      now_in         = now_ff;
      fire_in        = fire_ff;
      on_in          = on_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp.ready;
      rsp_fire_in    = rsp_fire_ff;
      rsp_on_in      = rsp_on_ff;
      active_in      = active_ff;
      track_in       = track_ff;
      wait_in        = wait_ff;
      phase_in       = phase_ff;
      hold_start_in  = hold_start_ff;
      phase_start_in = phase_start_ff;
      div_cmd.start  = 1'b0;
      div_cmd.divisor = {rate_eff, 1'b0};
      pulse          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               port_in  = req.port;
               raw_in   = req.fire_level;
               now_in   = req.now_us;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!port_ok || !cfg.mode[port_ff]) begin
               if (port_ok) begin
                  active_in[port_ff] = 1'b0;
                  track_in[port_ff]  = 1'b0;
                  wait_in[port_ff]   = 1'b0;
               end
               fire_in  = raw_ff;
               on_in    = 1'b0;
               state_in = ST_DONE;
            end else begin
               if (wait_ff[port_ff]) begin
                  if (!raw_ff) begin
                     wait_in[port_ff] = 1'b0;
                  end
               end else if (raw_ff) begin
                  if (!track_ff[port_ff]) begin
                     track_in[port_ff]      = 1'b1;
                     hold_start_in[port_ff] = now_ff;
                  end else if (hold_elapsed >= HOLD_TOGGLE_US) begin
                     if (!active_ff[port_ff]) begin
                        active_in[port_ff]      = 1'b1;
                        phase_in[port_ff]       = 1'b1;
                        phase_start_in[port_ff] = now_ff;
                     end else begin
                        active_in[port_ff] = 1'b0;
                     end
                     track_in[port_ff] = 1'b0;
                     wait_in[port_ff]  = 1'b1;
                  end
               end else begin
                  track_in[port_ff] = 1'b0;
               end
               div_cmd.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: begin
            if (active_ff[port_ff]) begin
               pulse = phase_ff[port_ff];
               if (phase_elapsed >= TIME_W'(div_sts.quotient)) begin
                  phase_in[port_ff]       = ~phase_ff[port_ff];
                  phase_start_in[port_ff] = now_ff;
                  pulse                   = ~phase_ff[port_ff];
               end
            end
            fire_in  = raw_ff | pulse;
            on_in    = active_ff[port_ff];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_fire_in  = fire_ff;
               rsp_on_in    = on_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         active_ff      <= '0;
         track_ff       <= '0;
         wait_ff        <= '0;
         phase_ff       <= '0;
         hold_start_ff  <= '0;
         phase_start_ff <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         active_ff      <= active_in;
         track_ff       <= track_in;
         wait_ff        <= wait_in;
         phase_ff       <= phase_in;
         hold_start_ff  <= hold_start_in;
         phase_start_ff <= phase_start_in;
      end
   end

   always_ff @(posedge clock) begin
      port_ff     <= port_in;
      raw_ff      <= raw_in;
      now_ff      <= now_in;
      fire_ff     <= fire_in;
      on_ff       <= on_in;
      rsp_fire_ff <= rsp_fire_in;
      rsp_on_ff   <= rsp_on_in;
   end

endmodule
